[src/pcx_pkg.sv]
// shared types and constants of the polyline segment crossing block
package pcx_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int ADDR_W       = $clog2(MAX_VERTICES);
	localparam int CNT_REG_W    = 7;
	localparam int WALK_W       = $clog2(MAX_VERTICES + 2);
	localparam int IDX_W        = 6;
	localparam int COORD_W      = 16;
	localparam int VERT_W       = 2 * COORD_W;
	localparam int DIFF_W       = COORD_W + 1;
	localparam int PROD_W       = 2 * DIFF_W;
	localparam int CROSS_W      = 2;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 7;
	localparam int QDEPTH       = 2;
	localparam int QPTR_W       = $clog2(QDEPTH);

	typedef enum logic [1:0] {
		MODE_IGNORE         = 2'd0,
		MODE_LOOKUP         = 2'd1,
		MODE_BORDER         = 2'd2,
		MODE_BORDER_SWAPPED = 2'd3
	} mode_t;

	typedef enum logic {
		KIND_LOAD = 1'b0,
		KIND_TEST = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_NONE,
		OP_WALK
	} op_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_WALK,
		BK_RESULT
	} bk_state_t;

	localparam logic [CFG_IDX_W-1:0] CFG_ZONE_MODE    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 1'b1;

	localparam logic [CROSS_W-1:0] CROSS_NONE = 2'd0;
	localparam logic [CROSS_W-1:0] CROSS_POS  = 2'd1;
	localparam logic [CROSS_W-1:0] CROSS_NEG  = 2'd2;

	typedef struct packed {
		op_t                 op;
		mode_t               mode;
		logic [WALK_W-1:0]   nvert;
		logic [WALK_W-1:0]   nreads;
		logic [ADDR_W-1:0]   addr;
		logic [COORD_W-1:0]  vx;
		logic [COORD_W-1:0]  vy;
		logic [COORD_W-1:0]  sx;
		logic [COORD_W-1:0]  sy;
		logic [COORD_W-1:0]  ex;
		logic [COORD_W-1:0]  ey;
	} cmd_t;

	typedef struct packed {
		logic valid;
		logic full;
	} q_status_t;

	function automatic logic signed [DIFF_W-1:0] diff(
		input logic [COORD_W-1:0] a,
		input logic [COORD_W-1:0] b
	);
		return $signed({a[COORD_W-1], a} - {b[COORD_W-1], b});
	endfunction

endpackage

[src/pcx_req_if.sv]
// input word channel: vertex loads and segment tests
interface pcx_req_if;
	import pcx_pkg::*;

	logic               valid;
	logic               ready;
	logic               kind;
	logic [IDX_W-1:0]   vertex_index;
	logic [COORD_W-1:0] vertex_x;
	logic [COORD_W-1:0] vertex_y;
	logic [COORD_W-1:0] start_x;
	logic [COORD_W-1:0] start_y;
	logic [COORD_W-1:0] end_x;
	logic [COORD_W-1:0] end_y;

	modport source (
		output valid, kind, vertex_index, vertex_x, vertex_y,
		output start_x, start_y, end_x, end_y,
		input  ready
	);

	modport sink (
		input  valid, kind, vertex_index, vertex_x, vertex_y,
		input  start_x, start_y, end_x, end_y,
		output ready
	);
endinterface

[src/pcx_rsp_if.sv]
// result word channel: crossing code
interface pcx_rsp_if;
	import pcx_pkg::*;

	logic               valid;
	logic               ready;
	logic [CROSS_W-1:0] crossing;

	modport source (output valid, crossing, input ready);
	modport sink (input valid, crossing, output ready);
endinterface

[src/pcx_front.sv]
// front end: configuration registers, word intake and command classification
module pcx_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pcx_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pcx_pkg::CFG_DATA_W-1:0] cfg_wdata,
	pcx_req_if.sink                        req,
	input  pcx_pkg::q_status_t             q_status,
	output logic                           push,
	output pcx_pkg::cmd_t                  push_cmd
);
	import pcx_pkg::*;

	mode_t                mode_q;
	logic [CNT_REG_W-1:0] count_q;
	logic [WALK_W-1:0]    nvert;
	logic                 in_range;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IGNORE;
			count_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ZONE_MODE:    mode_q  <= mode_t'(cfg_wdata[1:0]);
				CFG_VERTEX_COUNT: count_q <= CNT_REG_W'(cfg_wdata);
				default:          mode_q  <= mode_q;
			endcase
		end
	end

	always_comb begin
		if (32'(count_q) > MAX_VERTICES) begin
			nvert = WALK_W'(MAX_VERTICES);
		end else begin
			nvert = WALK_W'(count_q);
		end
	end

	assign in_range  = 32'(req.vertex_index) < MAX_VERTICES;
	assign req.ready = !q_status.full;
	assign push      = req.valid && req.ready && ((req.kind == KIND_TEST) || in_range);

	always_comb begin
		push_cmd.mode   = mode_q;
		push_cmd.nvert  = nvert;
		push_cmd.nreads = (mode_q == MODE_LOOKUP) ? nvert + WALK_W'(1) : nvert;
		push_cmd.addr   = ADDR_W'(req.vertex_index);
		push_cmd.vx     = req.vertex_x;
		push_cmd.vy     = req.vertex_y;
		push_cmd.sx     = req.start_x;
		push_cmd.sy     = req.start_y;
		push_cmd.ex     = req.end_x;
		push_cmd.ey     = req.end_y;
		if (req.kind == KIND_LOAD) begin
			push_cmd.op = OP_LOAD;
		end else if (mode_q == MODE_IGNORE || nvert == '0
				|| (mode_q != MODE_LOOKUP && nvert < WALK_W'(2))) begin
			push_cmd.op = OP_NONE;
		end else begin
			push_cmd.op = OP_WALK;
		end
	end
endmodule

[src/pcx_queue.sv]
// short command queue between front end and edge walker
module pcx_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  pcx_pkg::cmd_t      push_cmd,
	input  logic               pop,
	output pcx_pkg::q_status_t status,
	output pcx_pkg::cmd_t      head
);
	import pcx_pkg::*;

	cmd_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_push;
	logic              do_pop;

	assign status.valid = cnt_q != '0;
	assign status.full  = cnt_q == (QPTR_W + 1)'(QDEPTH);
	assign head         = entry_q[rd_ptr_q];
	assign do_push      = push && !status.full;
	assign do_pop       = pop && status.valid;

	function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end
endmodule

[src/pcx_back.sv]
// back end: vertex table, pipelined edge walk and result register
module pcx_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  pcx_pkg::cmd_t q_cmd,
	output logic          pop,
	pcx_rsp_if.source     rsp
);
	import pcx_pkg::*;

	logic [VERT_W-1:0]  mem [MAX_VERTICES];

	bk_state_t          state_q;
	bk_state_t          state_d;
	cmd_t               cur_q;
	logic [WALK_W-1:0]  rd_cnt_q;
	logic [WALK_W-1:0]  edge_cnt_q;
	logic [CROSS_W-1:0] res_q;
	logic [CROSS_W-1:0] res_d;
	logic               issue;
	logic [ADDR_W-1:0]  rd_addr;
	logic               hit;
	logic               done_walk;

	logic [VERT_W-1:0]  rdata_s1;
	logic               vld_s1;
	logic               first_s1;
	logic [VERT_W-1:0]  prev_q;

	logic               vld_s2;
	logic signed [DIFF_W-1:0] dbx_s2, dby_s2, dsax_s2, dsay_s2, deax_s2, deay_s2;
	logic signed [DIFF_W-1:0] dsgx_s2, dsgy_s2, dasx_s2, dasy_s2, dbsx_s2, dbsy_s2;

	logic               vld_s3;
	logic signed [PROD_W-1:0] p0a_s3, p0b_s3, p1a_s3, p1b_s3;
	logic signed [PROD_W-1:0] q0a_s3, q0b_s3, q1a_s3, q1b_s3;

	logic               vld_s4;
	logic               sp0_s4, sn0_s4, sp1_s4, sn1_s4;
	logic               tp0_s4, tn0_s4, tp1_s4, tn1_s4;

	// vertex a from the previous read, vertex b from the current one
	logic [COORD_W-1:0] ax, ay, bx, by;

	assign ax = prev_q[COORD_W-1:0];
	assign ay = prev_q[VERT_W-1:COORD_W];
	assign bx = rdata_s1[COORD_W-1:0];
	assign by = rdata_s1[VERT_W-1:COORD_W];

	assign issue   = (state_q == BK_WALK) && (rd_cnt_q < cur_q.nreads);
	assign rd_addr = (rd_cnt_q == cur_q.nvert) ? '0 : ADDR_W'(rd_cnt_q);
	assign pop     = q_valid && (state_q == BK_IDLE);

	assign hit = !((sp0_s4 && sp1_s4) || (sn0_s4 && sn1_s4))
		&& !((tp0_s4 && tp1_s4) || (tn0_s4 && tn1_s4));

	assign done_walk = (state_q == BK_WALK) && vld_s4
		&& (hit || (edge_cnt_q + WALK_W'(2)) == cur_q.nreads);

	always_comb begin
		res_d = CROSS_NONE;
		if (hit) begin
			unique case (cur_q.mode)
				MODE_LOOKUP:         res_d = CROSS_POS;
				MODE_BORDER:         res_d = sn0_s4 ? CROSS_POS : CROSS_NEG;
				MODE_BORDER_SWAPPED: res_d = sn0_s4 ? CROSS_NEG : CROSS_POS;
				default:             res_d = CROSS_NONE;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					unique case (q_cmd.op)
						OP_NONE: state_d = BK_RESULT;
						OP_WALK: state_d = BK_WALK;
						default: state_d = BK_IDLE;
					endcase
				end
			end
			BK_WALK: begin
				if (done_walk) begin
					state_d = BK_RESULT;
				end
			end
			BK_RESULT: begin
				if (rsp.ready) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			rd_cnt_q   <= '0;
			edge_cnt_q <= '0;
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			vld_s3     <= 1'b0;
			vld_s4     <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= issue && !done_walk;
			vld_s2  <= vld_s1 && !first_s1 && !done_walk;
			vld_s3  <= vld_s2 && !done_walk;
			vld_s4  <= vld_s3 && !done_walk;
			if (pop) begin
				rd_cnt_q   <= '0;
				edge_cnt_q <= '0;
			end else begin
				if (issue) begin
					rd_cnt_q <= rd_cnt_q + WALK_W'(1);
				end
				if (state_q == BK_WALK && vld_s4) begin
					edge_cnt_q <= edge_cnt_q + WALK_W'(1);
				end
			end
		end
	end

	// vertex table
	always_ff @(posedge clk) begin
		if (pop && q_cmd.op == OP_LOAD) begin
			mem[q_cmd.addr] <= {q_cmd.vy, q_cmd.vx};
		end
	end

	always_ff @(posedge clk) begin
		rdata_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		first_s1 <= rd_cnt_q == '0;
		if (pop) begin
			cur_q <= q_cmd;
		end
		if (pop) begin
			res_q <= CROSS_NONE;
		end else if (done_walk) begin
			res_q <= res_d;
		end
		if (vld_s1) begin
			prev_q <= rdata_s1;
		end
		// differences
		dbx_s2  <= diff(bx, ax);
		dby_s2  <= diff(by, ay);
		dsax_s2 <= diff(cur_q.sx, ax);
		dsay_s2 <= diff(cur_q.sy, ay);
		deax_s2 <= diff(cur_q.ex, ax);
		deay_s2 <= diff(cur_q.ey, ay);
		dsgx_s2 <= diff(cur_q.ex, cur_q.sx);
		dsgy_s2 <= diff(cur_q.ey, cur_q.sy);
		dasx_s2 <= diff(ax, cur_q.sx);
		dasy_s2 <= diff(ay, cur_q.sy);
		dbsx_s2 <= diff(bx, cur_q.sx);
		dbsy_s2 <= diff(by, cur_q.sy);
		// products
		p0a_s3 <= dsax_s2 * dby_s2;
		p0b_s3 <= dsay_s2 * dbx_s2;
		p1a_s3 <= deax_s2 * dby_s2;
		p1b_s3 <= deay_s2 * dbx_s2;
		q0a_s3 <= dasx_s2 * dsgy_s2;
		q0b_s3 <= dasy_s2 * dsgx_s2;
		q1a_s3 <= dbsx_s2 * dsgy_s2;
		q1b_s3 <= dbsy_s2 * dsgx_s2;
		// side signs
		sp0_s4 <= p0a_s3 > p0b_s3;
		sn0_s4 <= p0a_s3 < p0b_s3;
		sp1_s4 <= p1a_s3 > p1b_s3;
		sn1_s4 <= p1a_s3 < p1b_s3;
		tp0_s4 <= q0a_s3 > q0b_s3;
		tn0_s4 <= q0a_s3 < q0b_s3;
		tp1_s4 <= q1a_s3 > q1b_s3;
		tn1_s4 <= q1a_s3 < q1b_s3;
	end

	assign rsp.valid    = state_q == BK_RESULT;
	assign rsp.crossing = res_q;
endmodule

[src/polyline_segment_crossing_test.sv]
// Top level of the polyline segment crossing block.
// Load word: written into the vertex table when the back end pops it from the queue, no result.
// Test word in ignore mode or with no edges: no walk; result valid once the back end pops it.
// Walking test word: up to nreads vertices are read from the table, nreads = vertices in
// use (+1 for lookup zones), at most 65; one table read per cycle, one word at a time.
// Reset clears control state and both configuration registers, not the vertex table.
module polyline_segment_crossing_test (
	input  logic                           clk,
	input  logic                           arst_n,
	pcx_req_if.sink                        req,
	pcx_rsp_if.source                      rsp,
	input  logic                           cfg_we,
	input  logic [pcx_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pcx_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import pcx_pkg::*;

	q_status_t q_status;
	logic      push;
	cmd_t      push_cmd;
	logic      pop;
	cmd_t      head;

	pcx_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.q_status  (q_status),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	pcx_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.status   (q_status),
		.head     (head)
	);

	pcx_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_status.valid),
		.q_cmd   (head),
		.pop     (pop),
		.rsp     (rsp)
	);
endmodule

[src/pcx_checker.sv]
// port-level checks of the crossing block and their binding
module pcx_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        req_kind,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [pcx_pkg::CROSS_W-1:0] rsp_crossing
);
	import pcx_pkg::*;

	logic [3:0] pending_q;
	logic       test_in;
	logic       word_out;

	assign test_in  = req_valid && req_ready && (req_kind == KIND_TEST);
	assign word_out = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (test_in && !word_out) begin
			pending_q <= pending_q + 1'b1;
		end else if (word_out && !test_in) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	a_code_legal: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_crossing == CROSS_NONE || rsp_crossing == CROSS_POS
			|| rsp_crossing == CROSS_NEG))
		else $error("illegal crossing code");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		word_out |-> (pending_q != '0 || test_in))
		else $error("result word without a pending test");

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> rsp_valid)
		else $error("result valid dropped while stalled");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> $stable(rsp_crossing))
		else $error("result changed while stalled");
endmodule

bind polyline_segment_crossing_test pcx_checker u_pcx_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.req_kind     (req.kind),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_crossing (rsp.crossing)
);

[tb/sv/polyline_segment_crossing_test_tb.sv]
// self-checking testbench of the polyline segment crossing block with its own crossing predictor
module polyline_segment_crossing_test_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pcx_pkg::*;

	typedef struct {
		kind_t               kind;
		logic [IDX_W-1:0]    idx;
		logic [COORD_W-1:0]  vx;
		logic [COORD_W-1:0]  vy;
		logic [COORD_W-1:0]  sx;
		logic [COORD_W-1:0]  sy;
		logic [COORD_W-1:0]  ex;
		logic [COORD_W-1:0]  ey;
	} word_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	pcx_req_if req_ch();
	pcx_rsp_if rsp_ch();

	polyline_segment_crossing_test DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	word_t pending[$];
	logic [CROSS_W-1:0] crossing_due[$];
	logic [CROSS_W-1:0] want;

	logic [COORD_W-1:0] zone_x [MAX_VERTICES];
	logic [COORD_W-1:0] zone_y [MAX_VERTICES];
	mode_t zone_mode;
	int vertex_count;

	int req_issued;
	int req_accepted;
	int mismatches;
	int send_idle_pct;
	int recv_stall_pct;

	function automatic int side_sign(input longint px, input longint py, input longint ax,
			input longint ay, input longint bx, input longint by);
		longint c;
		c = (px - ax) * (by - ay) - (py - ay) * (bx - ax);
		if (c > 0)
			return 1;
		if (c < 0)
			return -1;
		return 0;
	endfunction

	function automatic bit edge_touched(input longint sx, input longint sy, input longint ex,
			input longint ey, input int a, input int b, output int start_side);
		longint x1, y1, x2, y2;
		int s0, s1, t0, t1;
		x1 = longint'($signed(zone_x[a]));
		y1 = longint'($signed(zone_y[a]));
		x2 = longint'($signed(zone_x[b]));
		y2 = longint'($signed(zone_y[b]));
		s0 = side_sign(sx, sy, x1, y1, x2, y2);
		s1 = side_sign(ex, ey, x1, y1, x2, y2);
		t0 = side_sign(x1, y1, sx, sy, ex, ey);
		t1 = side_sign(x2, y2, sx, sy, ex, ey);
		start_side = s0;
		return (s0 * s1 <= 0) && (t0 * t1 <= 0);
	endfunction

	function automatic logic [CROSS_W-1:0] predict_crossing(input logic [COORD_W-1:0] sx_in,
			input logic [COORD_W-1:0] sy_in, input logic [COORD_W-1:0] ex_in,
			input logic [COORD_W-1:0] ey_in);
		int n;
		int ss;
		longint sx, sy, ex, ey;
		if (zone_mode == MODE_IGNORE)
			return CROSS_NONE;
		n = (vertex_count > MAX_VERTICES) ? MAX_VERTICES : vertex_count;
		sx = longint'($signed(sx_in));
		sy = longint'($signed(sy_in));
		ex = longint'($signed(ex_in));
		ey = longint'($signed(ey_in));
		for (int i = 0; i + 1 < n; i++) begin
			if (edge_touched(sx, sy, ex, ey, i, i + 1, ss)) begin
				if (zone_mode == MODE_LOOKUP)
					return CROSS_POS;
				if (zone_mode == MODE_BORDER)
					return (ss < 0) ? CROSS_POS : CROSS_NEG;
				return (ss < 0) ? CROSS_NEG : CROSS_POS;
			end
		end
		if (zone_mode == MODE_LOOKUP && n > 0 && edge_touched(sx, sy, ex, ey, n - 1, 0, ss))
			return CROSS_POS;
		return CROSS_NONE;
	endfunction

	function automatic logic [COORD_W-1:0] pick_coord();
		logic [COORD_W-1:0] v;
		case ($urandom_range(9))
			6, 7: v = COORD_W'($urandom);
			8: begin
				case ($urandom_range(2))
					0: v = 16'h8000;
					1: v = 16'h7fff;
					default: v = '0;
				endcase
			end
			9: v = COORD_W'($urandom_range(6) - 3);
			default: v = COORD_W'($urandom_range(4000) - 2000);
		endcase
		return v;
	endfunction

	function automatic void push_load(input int idx, input int x, input int y);
		word_t w;
		w.kind = KIND_LOAD;
		w.idx = IDX_W'(idx);
		w.vx = COORD_W'(x);
		w.vy = COORD_W'(y);
		w.sx = COORD_W'($urandom);
		w.sy = COORD_W'($urandom);
		w.ex = COORD_W'($urandom);
		w.ey = COORD_W'($urandom);
		pending = {pending, w};
	endfunction

	function automatic void push_test(input int sx, input int sy, input int ex, input int ey);
		word_t w;
		w.kind = KIND_TEST;
		w.idx = IDX_W'($urandom);
		w.vx = COORD_W'($urandom);
		w.vy = COORD_W'($urandom);
		w.sx = COORD_W'(sx);
		w.sy = COORD_W'(sy);
		w.ex = COORD_W'(ex);
		w.ey = COORD_W'(ey);
		pending = {pending, w};
	endfunction

	function automatic void push_random();
		int k;
		logic [COORD_W-1:0] sx, sy, ex, ey;
		if ($urandom_range(99) < 25) begin
			push_load($urandom_range(MAX_VERTICES - 1), int'(pick_coord()), int'(pick_coord()));
		end else begin
			sx = pick_coord();
			sy = pick_coord();
			ex = pick_coord();
			ey = pick_coord();
			k = $urandom_range(MAX_VERTICES - 1);
			case ($urandom_range(7))
				0: begin
					sx = zone_x[k];
					sy = zone_y[k];
				end
				1: begin
					ex = zone_x[k];
					ey = zone_y[k];
				end
				default: ;
			endcase
			push_test(int'(sx), int'(sy), int'(ex), int'(ey));
		end
	endfunction

	// wait until every word is through and every crossing is back
	task automatic settle();
		@(negedge clk);
		while (pending.size() != 0 || req_issued != req_accepted || crossing_due.size() != 0)
			@(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_zone(input mode_t m, input int count);
		logic [CFG_DATA_W-1:0] d;
		d = CFG_DATA_W'($urandom);
		d[1:0] = m;
		write_reg(CFG_ZONE_MODE, d);
		zone_mode = m;
		write_reg(CFG_VERTEX_COUNT, CFG_DATA_W'(count));
		vertex_count = count;
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (!req_ch.valid || req_issued == req_accepted) begin
				if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req_ch.kind <= pending[0].kind;
					req_ch.vertex_index <= pending[0].idx;
					req_ch.vertex_x <= pending[0].vx;
					req_ch.vertex_y <= pending[0].vy;
					req_ch.start_x <= pending[0].sx;
					req_ch.start_y <= pending[0].sy;
					req_ch.end_x <= pending[0].ex;
					req_ch.end_y <= pending[0].ey;
					req_ch.valid <= 1'b1;
					void'(pending.pop_front());
					req_issued++;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
			rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (crossing_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("crossing word with none expected: got %0d", rsp_ch.crossing);
				end else begin
					want = crossing_due.pop_front();
					if (rsp_ch.crossing !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("crossing mismatch: expected %0d, got %0d",
								want, rsp_ch.crossing);
					end
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				if (req_ch.kind == KIND_LOAD) begin
					zone_x[req_ch.vertex_index] = req_ch.vertex_x;
					zone_y[req_ch.vertex_index] = req_ch.vertex_y;
				end else begin
					crossing_due = {crossing_due, predict_crossing(req_ch.start_x,
						req_ch.start_y, req_ch.end_x, req_ch.end_y)};
				end
				req_accepted <= req_accepted + 1;
			end
		end
	end

	initial begin
		#8_000_000;
		$display("[polyline_segment_crossing_test] ERROR");
		$finish;
	end

	initial begin
		int count;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.kind = 1'b0;
		req_ch.vertex_index = '0;
		req_ch.vertex_x = '0;
		req_ch.vertex_y = '0;
		req_ch.start_x = '0;
		req_ch.start_y = '0;
		req_ch.end_x = '0;
		req_ch.end_y = '0;
		rsp_ch.ready = 1'b0;
		req_issued = 0;
		req_accepted = 0;
		mismatches = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		zone_mode = MODE_IGNORE;
		vertex_count = 0;
		for (int i = 0; i < MAX_VERTICES; i++) begin
			zone_x[i] = '0;
			zone_y[i] = '0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// whole vertex table written before any walk
		for (int i = 0; i < MAX_VERTICES - 2; i++)
			push_load(i, int'(pick_coord()), int'(pick_coord()));
		push_load(MAX_VERTICES - 2, 32767, -32768);
		push_load(MAX_VERTICES - 1, -32768, 32767);
		settle();

		set_zone(MODE_LOOKUP, 4);
		push_load(0, -100, -100);
		push_load(1, 100, -100);
		push_load(2, 100, 100);
		push_load(3, -100, 100);
		push_test(0, 0, 200, 0);
		push_test(0, 0, 50, 50);
		// hit on the closing edge only
		push_test(-200, 0, -50, 0);
		push_test(100, 100, 200, 200);
		// collinear with an edge but apart from it
		push_test(-200, -100, -150, -100);
		push_test(-32768, -32768, 32767, 32767);
		settle();
		set_zone(MODE_LOOKUP, 1);
		push_test(-200, -200, 0, 0);
		push_test(0, 0, 10, 0);
		settle();
		set_zone(MODE_LOOKUP, 0);
		push_test(0, 0, 200, 0);
		settle();
		set_zone(MODE_BORDER, 4);
		push_test(0, 0, 200, 0);
		push_test(200, 0, 0, 0);
		push_test(-200, 0, -50, 0);
		settle();
		set_zone(MODE_BORDER_SWAPPED, 4);
		push_test(0, 0, 200, 0);
		push_test(200, 0, 0, 0);
		settle();
		set_zone(MODE_IGNORE, 4);
		push_test(0, 0, 200, 0);
		settle();
		set_zone(MODE_LOOKUP, 127);
		push_test(32767, 32767, -32768, -32768);
		push_test(-32768, 32767, 32767, -32768);

		for (int p = 0; p < 16; p++) begin
			settle();
			case (p % 5)
				0: count = $urandom_range(4, 12);
				1: count = $urandom_range(13, 63);
				2: count = MAX_VERTICES;
				3: count = (p == 3) ? 127 : $urandom_range(65, 127);
				default: count = (p == 4) ? 0 : $urandom_range(0, 3);
			endcase
			set_zone(mode_t'(p % 4), count);
			case ((p / 4) % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 82;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 82;
				end
				default: begin
					send_idle_pct = 38;
					recv_stall_pct = 38;
				end
			endcase
			repeat (50) push_random();
			if (p % 4 == 1)
				settle();
			repeat (50) push_random();
		end
		settle();

		if (mismatches == 0 && crossing_due.size() == 0)
			$display("[polyline_segment_crossing_test] OK");
		else
			$display("[polyline_segment_crossing_test] ERROR");
		$finish;
	end

endmodule
